// ----- src/sector_cache_clock_replacer_top_macros.svh -----
// Assertion macros for the sector cache clock replacer.
// Depends on signals named clock and reset in the including module.
`ifndef SECTOR_CACHE_CLOCK_REPLACER_TOP_MACROS_SVH
`define SECTOR_CACHE_CLOCK_REPLACER_TOP_MACROS_SVH

// same-cycle implication
`define SCCR_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sccr assertion failed");

// next-cycle implication
`define SCCR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sccr assertion failed");

`endif

// ----- src/sccr_pkg.sv -----
// Shared constants, types and helpers for the sector cache clock replacer.
// No dependencies.
package sccr_pkg;

   localparam int SLOTS    = 64;
   localparam int IDX_W    = $clog2(SLOTS);
   localparam int CNT_W    = $clog2(SLOTS + 1);
   localparam int SECTOR_W = 32;
   localparam int SLOT_W   = 6;

   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [CNT_W-1:0]    cnt_type;
   typedef logic [SECTOR_W-1:0] sector_type;
   typedef logic [SLOT_W-1:0]   slot_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SWEEP,
      ST_EVICT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       rd_en;
      idx_type    rd_addr;
      logic       wr_en;
      idx_type    wr_addr;
      sector_type wr_data;
   } ram_req_type;

   typedef struct packed {
      logic       hit;
      slot_type   slot;
      logic       evicted;
      sector_type evicted_sector;
   } result_type;

   function automatic slot_type to_slot(idx_type idx);
      logic [IDX_W+SLOT_W-1:0] ext;
      ext = {{SLOT_W{1'b0}}, idx};
      return ext[SLOT_W-1:0];
   endfunction

   function automatic idx_type next_idx(idx_type idx);
      return (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

endpackage

// ----- src/sccr_tag_ram.sv -----
// Tag memory: one write port, one read port, registered read data.
// Depends on sccr_pkg.
module sccr_tag_ram (
   input  logic                  clock,
   input  sccr_pkg::ram_req_type ram_req,
   output sccr_pkg::sector_type  rd_data
);

   sccr_pkg::sector_type tag_mem [sccr_pkg::SLOTS];
   sccr_pkg::sector_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         tag_mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= tag_mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/sccr_ctrl.sv -----
// Lookup, fill and clock sweep sequencer with fill count, hand and reference bit memory.
// Depends on sccr_pkg and sector_cache_clock_replacer_top_macros.svh.
`include "sector_cache_clock_replacer_top_macros.svh"

module sccr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  sccr_pkg::sector_type  req_sector,
   output logic                  req_stall,
   output sccr_pkg::ram_req_type ram_req,
   input  sccr_pkg::sector_type  ram_rd_data,
   output logic                  res_valid,
   output sccr_pkg::result_type  res,
   input  logic                  res_take
);

   sccr_pkg::state_type  state_ff, state_in;
   sccr_pkg::cnt_type    count_ff, count_in;
   sccr_pkg::cnt_type    issue_ff, issue_in;
   sccr_pkg::idx_type    chk_ff, chk_in;
   logic                 pend_ff, pend_in;
   sccr_pkg::idx_type    hand_ff, hand_in;
   sccr_pkg::idx_type    start_ff, start_in;
   sccr_pkg::sector_type sector_ff, sector_in;
   sccr_pkg::result_type res_ff, res_in;

   logic                 ref_mem [sccr_pkg::SLOTS];
   logic                 ref_rd_ff;
   logic                 ref_rd_en;
   sccr_pkg::idx_type    ref_rd_addr;
   logic                 ref_wr_en;
   sccr_pkg::idx_type    ref_wr_addr;
   logic                 ref_wr_data;

   logic              hit_now;
   logic              scan_end;
   logic              ref_cur;
   logic              lap_end;
   sccr_pkg::idx_type hand_nx;
   sccr_pkg::idx_type fill_idx;

   assign hit_now  = pend_ff && (ram_rd_data == sector_ff);
   assign scan_end = (issue_ff == count_ff) && !hit_now;
   assign ref_cur  = ref_rd_ff;
   assign hand_nx  = sccr_pkg::next_idx(hand_ff);
   assign lap_end  = (hand_nx == start_ff);
   assign fill_idx = count_ff[sccr_pkg::IDX_W-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sccr_pkg::ST_IDLE: begin
            if (req_valid) state_in = sccr_pkg::ST_SCAN;
         end
         sccr_pkg::ST_SCAN: begin
            priority if (hit_now) state_in = sccr_pkg::ST_DONE;
            else if (scan_end && (count_ff != sccr_pkg::FULL_CNT)) state_in = sccr_pkg::ST_DONE;
            else if (scan_end) state_in = sccr_pkg::ST_SWEEP;
            else state_in = sccr_pkg::ST_SCAN;
         end
         sccr_pkg::ST_SWEEP: begin
            if (!ref_cur || lap_end) state_in = sccr_pkg::ST_EVICT;
         end
         sccr_pkg::ST_EVICT: begin
            state_in = sccr_pkg::ST_DONE;
         end
         sccr_pkg::ST_DONE: begin
            if (res_take) state_in = sccr_pkg::ST_IDLE;
         end
         default: state_in = sccr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      count_in    = count_ff;
      issue_in    = issue_ff;
      chk_in      = chk_ff;
      pend_in     = 1'b0;
      hand_in     = hand_ff;
      start_in    = start_ff;
      sector_in   = sector_ff;
      res_in      = res_ff;
      ram_req     = '0;
      ref_rd_en   = 1'b0;
      ref_rd_addr = '0;
      ref_wr_en   = 1'b0;
      ref_wr_addr = '0;
      ref_wr_data = 1'b0;
      unique case (state_ff)
         sccr_pkg::ST_IDLE: begin
            if (req_valid) begin
               sector_in = req_sector;
               issue_in  = '0;
            end
         end
         sccr_pkg::ST_SCAN: begin
            priority if (hit_now) begin
               res_in = '{hit: 1'b1, slot: sccr_pkg::to_slot(chk_ff),
                          evicted: 1'b0, evicted_sector: '0};
            end else if (scan_end && (count_ff != sccr_pkg::FULL_CNT)) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = fill_idx;
               ram_req.wr_data = sector_ff;
               ref_wr_en       = 1'b1;
               ref_wr_addr     = fill_idx;
               ref_wr_data     = 1'b1;
               count_in        = count_ff + 1'b1;
               res_in = '{hit: 1'b0, slot: sccr_pkg::to_slot(fill_idx),
                          evicted: 1'b0, evicted_sector: '0};
            end else if (scan_end) begin
               start_in    = hand_ff;
               ref_rd_en   = 1'b1;
               ref_rd_addr = hand_ff;
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = issue_ff[sccr_pkg::IDX_W-1:0];
               chk_in          = issue_ff[sccr_pkg::IDX_W-1:0];
               issue_in        = issue_ff + 1'b1;
               pend_in         = 1'b1;
            end
         end
         sccr_pkg::ST_SWEEP: begin
            if (ref_cur) begin
               ref_wr_en   = 1'b1;
               ref_wr_addr = hand_ff;
               ref_wr_data = 1'b0;
               hand_in     = hand_nx;
               if (lap_end) begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = hand_nx;
               end else begin
                  ref_rd_en   = 1'b1;
                  ref_rd_addr = hand_nx;
               end
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = hand_ff;
            end
         end
         sccr_pkg::ST_EVICT: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = hand_ff;
            ram_req.wr_data = sector_ff;
            ref_wr_en       = 1'b1;
            ref_wr_addr     = hand_ff;
            ref_wr_data     = 1'b1;
            res_in = '{hit: 1'b0, slot: sccr_pkg::to_slot(hand_ff),
                       evicted: 1'b1, evicted_sector: ram_rd_data};
         end
         sccr_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ref_wr_en) begin
         ref_mem[ref_wr_addr] <= ref_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ref_rd_en) begin
         ref_rd_ff <= ref_mem[ref_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sccr_pkg::ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         hand_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         hand_ff  <= hand_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff  <= issue_in;
      chk_ff    <= chk_in;
      start_ff  <= start_in;
      sector_ff <= sector_in;
      res_ff    <= res_in;
   end

   assign req_stall = (state_ff != sccr_pkg::ST_IDLE);
   assign res_valid = (state_ff == sccr_pkg::ST_DONE);
   assign res       = res_ff;

   `SCCR_ASSERT_IMPL(a_count_range, 1'b1, count_ff <= sccr_pkg::FULL_CNT)
   `SCCR_ASSERT_IMPL(a_sweep_full, state_ff == sccr_pkg::ST_SWEEP, count_ff == sccr_pkg::FULL_CNT)
   `SCCR_ASSERT_IMPL(a_issue_bound, state_ff == sccr_pkg::ST_SCAN, issue_ff <= count_ff)
   `SCCR_ASSERT_NEXT(a_accept_scan, state_ff == sccr_pkg::ST_IDLE && req_valid, state_ff == sccr_pkg::ST_SCAN)

endmodule

// ----- src/sector_cache_clock_replacer_top.sv -----
// Top level of the sector cache clock replacer: sequencer, tag memory, response register.
// Depends on sccr_pkg, sccr_tag_ram, sccr_ctrl and sector_cache_clock_replacer_top_macros.svh.
//
//   channel  | direction | handshake           | payload
//   req      | in        | req_valid/req_stall | req_sector[31:0]
//   rsp      | out       | rsp_valid/rsp_stall | rsp_hit, rsp_slot[5:0], rsp_evicted,
//            |           |                     |   rsp_evicted_sector[31:0]
//
// One request at a time. Tags are walked one per cycle from the tag memory over the filled
// slots: a hit ends the walk, and a miss with a free slot fills the next free slot.
// A miss on a full cache adds the clock sweep, one reference bit per cycle, over at most
// every slot once, plus a read of the victim tag.
// Reset empties the cache and parks the hand at slot 0; a reference bit is set when its slot
// fills, before any sweep reads it.
// A stalled response holds in its register; the next request completes into it once taken.
`include "sector_cache_clock_replacer_top_macros.svh"

module sector_cache_clock_replacer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_sector,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [5:0]  rsp_slot,
   output logic        rsp_evicted,
   output logic [31:0] rsp_evicted_sector
);

   sccr_pkg::ram_req_type ram_req;
   sccr_pkg::sector_type  ram_rd_data;
   sccr_pkg::result_type  res;
   logic                  res_valid;
   logic                  rsp_free;

   logic                 rsp_valid_ff, rsp_valid_in;
   sccr_pkg::result_type rsp_ff, rsp_in;

   sccr_tag_ram u_tag_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   sccr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_sector  (req_sector),
      .req_stall   (req_stall),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data),
      .res_valid   (res_valid),
      .res         (res),
      .res_take    (rsp_free)
   );

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_free) begin
         rsp_valid_in = res_valid;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_ff.hit;
   assign rsp_slot           = rsp_ff.slot;
   assign rsp_evicted        = rsp_ff.evicted;
   assign rsp_evicted_sector = rsp_ff.evicted_sector;

   `SCCR_ASSERT_IMPL(a_hit_no_evict, rsp_valid_ff && rsp_ff.hit, !rsp_ff.evicted)
   `SCCR_ASSERT_IMPL(a_evict_zero, rsp_valid_ff && !rsp_ff.evicted, rsp_ff.evicted_sector == '0)
   `SCCR_ASSERT_NEXT(a_load, res_valid && rsp_free, rsp_valid_ff)

endmodule
